>>> hdl/stt_pkg.sv
package stt_pkg;

  localparam int unsigned DefaultEntries = 16;

  typedef enum logic [1:0] {
    STATUS_IGNORED  = 2'd0,
    STATUS_UPDATED  = 2'd1,
    STATUS_REPLACED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  // One report as held for the duration of its search and write.
  typedef struct packed {
    logic [7:0]         sat_id;
    logic signed [31:0] report_time;
    logic               time_known;
    logic signed [10:0] elevation;
    logic               elevation_known;
    logic [11:0]        azimuth;
    logic               azimuth_known;
    logic [6:0]         signal_to_noise;
    logic               snr_known;
    logic               in_use;
    logic               in_use_known;
  } report_t;

  // Search state that travels down the row of entries.
  typedef struct packed {
    logic               valid;
    logic               found;
    logic signed [31:0] min_time;
    logic [7:0]         min_id;
  } probe_t;

endpackage

>>> hdl/stt_cell.sv
module stt_cell import stt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = DefaultEntries,
  parameter int unsigned CELL_IDX      = 0,
  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  report_t       report,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_idx,
  input  probe_t        probe_in,
  input  logic [IW-1:0] hit_idx_in,
  input  logic [IW-1:0] min_idx_in,
  output probe_t        probe_out,
  output logic [IW-1:0] hit_idx_out,
  output logic [IW-1:0] min_idx_out
);

  localparam logic [IW-1:0] MyIdx = IW'(CELL_IDX);

  logic [7:0]         entry_sat_id;
  logic signed [31:0] entry_time;
  logic signed [10:0] entry_elevation;
  logic [11:0]        entry_azimuth;
  logic [6:0]         entry_snr;
  logic               entry_in_use;

  probe_t        probe_next;
  logic [IW-1:0] hit_idx_next;
  logic [IW-1:0] min_idx_next;

  always_comb begin
    probe_next   = probe_in;
    hit_idx_next = hit_idx_in;
    min_idx_next = min_idx_in;
    if (!probe_in.found && (entry_sat_id == report.sat_id)) begin
      probe_next.found = 1'b1;
      hit_idx_next     = MyIdx;
    end
    // The first entry seeds the minimum; later ones replace it only when
    // strictly older, so the lowest index wins a tie.
    if ((CELL_IDX == 0) || (entry_time < probe_in.min_time)) begin
      probe_next.min_time = entry_time;
      probe_next.min_id   = entry_sat_id;
      min_idx_next        = MyIdx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
    end
    probe_out.found    <= probe_next.found;
    probe_out.min_time <= probe_next.min_time;
    probe_out.min_id   <= probe_next.min_id;
    hit_idx_out        <= hit_idx_next;
    min_idx_out        <= min_idx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_sat_id    <= '0;
      entry_time      <= '0;
      entry_elevation <= '0;
      entry_azimuth   <= '0;
      entry_snr       <= '0;
      entry_in_use    <= 1'b0;
    end else if (wr_en && (wr_idx == MyIdx)) begin
      entry_sat_id <= report.sat_id;
      if (report.time_known) begin
        entry_time <= report.report_time;
      end
      if (report.elevation_known) begin
        entry_elevation <= report.elevation;
      end
      if (report.azimuth_known) begin
        entry_azimuth <= report.azimuth;
      end
      if (report.snr_known) begin
        entry_snr <= report.signal_to_noise;
      end
      if (report.in_use_known) begin
        entry_in_use <= report.in_use;
      end
    end
  end

endmodule

>>> hdl/satellite_track_table_unit.sv
// A report with a nonzero id is searched for by walking once down the row of entry cells,
// one cell per cycle; a report with id 0 skips the search and goes straight to its result.
// One item at a time: a new report is taken only once the last result is in the output register.
// Reset (synchronous, active high) clears every entry to zero and empties the search row
// and the output register.
module satellite_track_table_unit import stt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = DefaultEntries
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         sat_id,
  input  logic signed [31:0] report_time,
  input  logic               time_known,
  input  logic signed [10:0] elevation,
  input  logic               elevation_known,
  input  logic [11:0]        azimuth,
  input  logic               azimuth_known,
  input  logic [6:0]         signal_to_noise,
  input  logic               snr_known,
  input  logic               in_use,
  input  logic               in_use_known,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         slot,
  output logic [1:0]         status,
  output logic [7:0]         evicted_id
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  state_t  state, state_next;
  report_t report;
  logic    launch, launch_next;

  logic [IW-1:0] pick_idx, pick_idx_next;
  status_t       res_status, res_status_next;
  logic [7:0]    res_evicted, res_evicted_next;

  logic          in_accept;
  logic          out_free;
  logic          load_out;
  logic          wr_en;

  probe_t        chain   [TABLE_ENTRIES+1];
  logic [IW-1:0] hit_idx [TABLE_ENTRIES+1];
  logic [IW-1:0] min_idx [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] probe_live;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Entry to the row: only the valid bit matters, the first cell seeds the rest.
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = launch;
    hit_idx[0]     = '0;
    min_idx[0]     = '0;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    stt_cell #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .CELL_IDX     (g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .report     (report),
      .wr_en      (wr_en),
      .wr_idx     (pick_idx),
      .probe_in   (chain[g]),
      .hit_idx_in (hit_idx[g]),
      .min_idx_in (min_idx[g]),
      .probe_out  (chain[g+1]),
      .hit_idx_out(hit_idx[g+1]),
      .min_idx_out(min_idx[g+1])
    );
    assign probe_live[g] = chain[g+1].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= launch_next;
    end
  end

  always_comb begin
    state_next       = state;
    launch_next      = 1'b0;
    pick_idx_next    = pick_idx;
    res_status_next  = res_status;
    res_evicted_next = res_evicted;
    in_stall         = 1'b1;
    load_out         = 1'b0;
    wr_en            = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          pick_idx_next    = '0;
          res_evicted_next = '0;
          if (sat_id == '0) begin
            res_status_next = STATUS_IGNORED;
            state_next      = ST_FINISH;
          end else begin
            launch_next = 1'b1;
            state_next  = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (chain[TABLE_ENTRIES].valid) begin
          if (chain[TABLE_ENTRIES].found) begin
            pick_idx_next    = hit_idx[TABLE_ENTRIES];
            res_status_next  = STATUS_UPDATED;
            res_evicted_next = '0;
          end else begin
            pick_idx_next    = min_idx[TABLE_ENTRIES];
            res_status_next  = STATUS_REPLACED;
            res_evicted_next = chain[TABLE_ENTRIES].min_id;
          end
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          load_out   = 1'b1;
          wr_en      = (res_status != STATUS_IGNORED);
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pick_idx    <= pick_idx_next;
    res_status  <= res_status_next;
    res_evicted <= res_evicted_next;
    if (in_accept) begin
      report.sat_id          <= sat_id;
      report.report_time     <= report_time;
      report.time_known      <= time_known;
      report.elevation       <= elevation;
      report.elevation_known <= elevation_known;
      report.azimuth         <= azimuth;
      report.azimuth_known   <= azimuth_known;
      report.signal_to_noise <= signal_to_noise;
      report.snr_known       <= snr_known;
      report.in_use          <= in_use;
      report.in_use_known    <= in_use_known;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      slot       <= 4'(pick_idx);
      status     <= res_status;
      evicted_id <= res_evicted;
    end
  end

`ifndef SYNTH
  // Only one search may be in flight in the row at any time.
  a_one_probe: assert property (@(posedge clk) disable iff (rst)
    $onehot0(probe_live))
    else $error("more than one search in the entry row");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state != ST_IDLE))
    else $error("item accepted but control stayed idle");

  a_tail_in_search: assert property (@(posedge clk) disable iff (rst)
    chain[TABLE_ENTRIES].valid |-> (state == ST_SEARCH))
    else $error("search finished outside the search state");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FINISH))
    else $error("result appeared without a finished item");

  a_no_write_ignored: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (report.sat_id != '0))
    else $error("table written for an ignored report");
`endif

endmodule

>>> bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;

  localparam int Entries = DefaultEntries;
  localparam int QuietLimit = 3000;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic [3:0] slot;
    status_t    status;
    logic [7:0] evicted_id;
  } outcome_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         sat_id;
  logic signed [31:0] report_time;
  logic               time_known;
  logic signed [10:0] elevation;
  logic               elevation_known;
  logic [11:0]        azimuth;
  logic               azimuth_known;
  logic [6:0]         signal_to_noise;
  logic               snr_known;
  logic               in_use;
  logic               in_use_known;
  logic               out_valid;
  logic               out_stall;
  logic [3:0]         slot;
  logic [1:0]         status;
  logic [7:0]         evicted_id;

  // Shadow copy of the track table.
  logic [7:0]         track_id        [Entries];
  logic signed [31:0] track_time      [Entries];
  logic [10:0]        track_elevation [Entries];
  logic [11:0]        track_azimuth   [Entries];
  logic [6:0]         track_snr       [Entries];
  logic               track_in_use    [Entries];

  outcome_t pending_outcomes[$];
  int       errors;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       hold_left;
  int       quiet_cycles;
  int       traffic_clock;

  satellite_track_table_unit #(.TABLE_ENTRIES(Entries)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sat_id(sat_id),
    .report_time(report_time),
    .time_known(time_known),
    .elevation(elevation),
    .elevation_known(elevation_known),
    .azimuth(azimuth),
    .azimuth_known(azimuth_known),
    .signal_to_noise(signal_to_noise),
    .snr_known(snr_known),
    .in_use(in_use),
    .in_use_known(in_use_known),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .slot(slot),
    .status(status),
    .evicted_id(evicted_id)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_tracks();
    int k;
    for (k = 0; k < Entries; k++) begin
      track_id[k] = '0;
      track_time[k] = '0;
      track_elevation[k] = '0;
      track_azimuth[k] = '0;
      track_snr[k] = '0;
      track_in_use[k] = 1'b0;
    end
  endfunction

  // Finds the entry a report lands in, updates the shadow table and
  // returns the result the block should give for it.
  function automatic outcome_t predict_report(report_t r);
    outcome_t o;
    int k;
    int pick;
    bit found;
    o.slot = '0;
    o.status = STATUS_IGNORED;
    o.evicted_id = '0;
    if (r.sat_id == 8'd0) return o;
    found = 1'b0;
    pick = 0;
    for (k = 0; k < Entries; k++) begin
      if (!found && track_id[k] == r.sat_id) begin
        pick = k;
        found = 1'b1;
      end
    end
    if (found) begin
      o.status = STATUS_UPDATED;
    end else begin
      // Strict less-than keeps the lowest entry among equal oldest times.
      for (k = 1; k < Entries; k++) begin
        if (track_time[k] < track_time[pick]) pick = k;
      end
      o.status = STATUS_REPLACED;
      o.evicted_id = track_id[pick];
    end
    o.slot = pick[3:0];
    track_id[pick] = r.sat_id;
    if (r.time_known) track_time[pick] = r.report_time;
    if (r.elevation_known) track_elevation[pick] = r.elevation;
    if (r.azimuth_known) track_azimuth[pick] = r.azimuth;
    if (r.snr_known) track_snr[pick] = r.signal_to_noise;
    if (r.in_use_known) track_in_use[pick] = r.in_use;
    return o;
  endfunction

  function automatic report_t build_report(logic [7:0] id, logic signed [31:0] t, bit t_known,
                                           logic [10:0] elev, logic [11:0] az, logic [6:0] snr,
                                           bit use_fix, bit others_known);
    report_t r;
    r.sat_id = id;
    r.report_time = t;
    r.time_known = t_known;
    r.elevation = elev;
    r.elevation_known = others_known;
    r.azimuth = az;
    r.azimuth_known = others_known;
    r.signal_to_noise = snr;
    r.snr_known = others_known;
    r.in_use = use_fix;
    r.in_use_known = others_known;
    return r;
  endfunction

  // Mostly a small pool of satellites reported with a slowly advancing
  // time, so that the table sees both refreshes and oldest-entry evictions.
  function automatic report_t make_traffic_report();
    report_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 6) r.sat_id = 8'd0;
    else if (pick < 14) r.sat_id = 8'($urandom_range(255, 1));
    else r.sat_id = 8'($urandom_range(22, 1));
    traffic_clock += $urandom_range(3);
    pick = $urandom_range(99);
    if (pick < 8) r.report_time = $urandom;
    else if (pick < 9) r.report_time = 32'sh7fffffff;
    else if (pick < 11) r.report_time = 32'sh80000000;
    else r.report_time = traffic_clock;
    r.time_known = ($urandom_range(99) < 85);
    r.elevation = 11'($urandom);
    r.elevation_known = 1'($urandom_range(1));
    r.azimuth = 12'($urandom);
    r.azimuth_known = 1'($urandom_range(1));
    r.signal_to_noise = 7'($urandom);
    r.snr_known = 1'($urandom_range(1));
    r.in_use = 1'($urandom_range(1));
    r.in_use_known = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic offer_report(input report_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sat_id = r.sat_id;
    report_time = r.report_time;
    time_known = r.time_known;
    elevation = r.elevation;
    elevation_known = r.elevation_known;
    azimuth = r.azimuth;
    azimuth_known = r.azimuth_known;
    signal_to_noise = r.signal_to_noise;
    snr_known = r.snr_known;
    in_use = r.in_use;
    in_use_known = r.in_use_known;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_outcomes.push_back(predict_report(r));
  endtask

  task automatic test_ignored_reports();
    offer_report(build_report(8'd0, 32'sh7fffffff, 1'b1, 11'h7ff, 12'hfff, 7'h7f, 1'b1, 1'b1));
    offer_report(build_report(8'd0, 32'sh80000000, 1'b0, 11'h000, 12'h000, 7'h00, 1'b0, 1'b0));
  endtask

  // Starts from the cleared table, where every time is zero, and checks
  // that the time compare is signed.
  task automatic test_first_fill();
    offer_report(build_report(8'd255, 32'sd0, 1'b0, 11'd0, 12'd0, 7'd0, 1'b0, 1'b0));
    offer_report(build_report(8'd7, 32'sd0, 1'b0, 11'd0, 12'd0, 7'd0, 1'b0, 1'b0));
    offer_report(build_report(8'd7, 32'sd100, 1'b1, 11'd450, 12'd1800, 7'd40, 1'b1, 1'b1));
    offer_report(build_report(8'd9, 32'sh80000000, 1'b1, 11'd0, 12'd0, 7'd0, 1'b0, 1'b1));
    offer_report(build_report(8'd10, 32'sh7fffffff, 1'b1, 11'd0, 12'd0, 7'd0, 1'b1, 1'b1));
    offer_report(build_report(8'd11, 32'sd5, 1'b1, 11'd0, 12'd0, 7'd0, 1'b1, 1'b1));
  endtask

  task automatic test_field_extremes();
    offer_report(build_report(8'd10, 32'sh7fffffff, 1'b1, 11'h400, 12'hfff, 7'h7f, 1'b1, 1'b1));
    offer_report(build_report(8'd10, 32'sh7fffffff, 1'b1, 11'h3ff, 12'h000, 7'h00, 1'b0, 1'b1));
    offer_report(build_report(8'd11, 32'sd5, 1'b1, -11'sd900, 12'd3599, 7'd99, 1'b1, 1'b1));
    offer_report(build_report(8'd11, 32'sd5, 1'b0, 11'sd900, 12'd3600, 7'd100, 1'b0, 1'b1));
  endtask

  // The remaining entries all hold time zero, so new satellites must fill
  // them from the lowest entry up.
  task automatic test_equal_times();
    int k;
    for (k = 0; k < Entries - 3; k++) begin
      offer_report(build_report(8'(20 + k), 32'sd50, 1'b1, 11'd0, 12'd0, 7'd0, 1'b0, 1'b0));
    end
  endtask

  task automatic test_receiver_hold();
    int k;
    send_idle_pct = 0;
    @(posedge clk);
    hold_left = HoldCycles;
    for (k = 0; k < 12; k++) offer_report(make_traffic_report());
  endtask

  task automatic test_mixed_traffic(input int sender_pct, input int receiver_pct,
                                    input int count);
    report_t r;
    int sent;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    sent = 0;
    while (sent < count) begin
      r = make_traffic_report();
      offer_report(r);
      sent++;
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: slot %0d status %0d evicted_id %0d",
                 $time, slot, status, evicted_id);
      end else begin
        want = pending_outcomes.pop_front();
        if (slot !== want.slot || status !== want.status ||
            evicted_id !== want.evicted_id) begin
          errors++;
          if (slot !== want.slot)
            $display("%0t: slot expected %0d, got %0d", $time, want.slot, slot);
          if (status !== want.status)
            $display("%0t: status expected %0d, got %0d", $time, want.status, status);
          if (evicted_id !== want.evicted_id)
            $display("%0t: evicted_id expected %0d, got %0d", $time, want.evicted_id,
                     evicted_id);
        end
      end
    end
  end

  // Ends a run in which nothing moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("satellite_track_table_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    sat_id = '0;
    report_time = '0;
    time_known = 1'b0;
    elevation = '0;
    elevation_known = 1'b0;
    azimuth = '0;
    azimuth_known = 1'b0;
    signal_to_noise = '0;
    snr_known = 1'b0;
    in_use = 1'b0;
    in_use_known = 1'b0;
    out_stall = 1'b0;
    errors = 0;
    hold_left = 0;
    quiet_cycles = 0;
    traffic_clock = -40;
    send_idle_pct = 34;
    recv_idle_pct = 64;
    clear_tracks();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_ignored_reports();
    test_first_fill();
    test_field_extremes();
    test_equal_times();
    test_receiver_hold();
    test_mixed_traffic(34, 64, 540);
    test_mixed_traffic(64, 34, 540);
    test_mixed_traffic(0, 0, 540);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (Entries + 8) @(posedge clk);
    if (errors == 0) begin
      $display("satellite_track_table_unit test passed");
    end else begin
      $display("satellite_track_table_unit test failed");
    end
    $finish;
  end

endmodule
